>>> rtl/life_rle_pattern_decoder_assert.svh
// Assertion macros used by the decoder's checker
`ifndef LIFE_RLE_PATTERN_DECODER_ASSERT_SVH
`define LIFE_RLE_PATTERN_DECODER_ASSERT_SVH

// Same-cycle implication
`define LRLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life rle decoder: same-cycle check failed");

// Next-cycle implication
`define LRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life rle decoder: next-cycle check failed");

`endif

>>> rtl/lrle_pkg.sv
// Shared types and constants of the Life RLE pattern decoder
`timescale 1ns / 1ps
package lrle_pkg;

    localparam int GRID_WIDTH_DEF  = 1024;
    localparam int GRID_HEIGHT_DEF = 512;

    localparam logic [9:0] COUNT_MAX = 10'd1023;

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        TK_NONE,
        TK_DIGIT,
        TK_RUN,
        TK_ROW,
        TK_END
    } t_tok_kind;

    typedef struct packed {
        logic       start;
        t_tok_kind  kind;
        logic [3:0] arg;
    } t_token;

endpackage

>>> rtl/lrle_front.sv
// Front end: tracks header/body phase and turns characters into tokens
`timescale 1ns / 1ps
module lrle_front
    import lrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    output logic       o_emit,
    output t_token     o_token
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIPLINE,
        PH_BODY,
        PH_DONE
    } t_phase;

    t_phase     r_phase;
    t_phase     n_phase;
    t_tok_kind  body_kind;
    logic [3:0] body_arg;

    always_comb begin
        body_arg = 4'd0;
        if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            body_kind = TK_DIGIT;
            body_arg  = i_char[3:0];
        end else if (i_char == CH_B || i_char == CH_O) begin
            body_kind = TK_RUN;
            body_arg  = {3'b000, i_char == CH_O};
        end else if (i_char == CH_DOLLAR) begin
            body_kind = TK_ROW;
        end else if (i_char == CH_BANG) begin
            body_kind = TK_END;
        end else begin
            body_kind = TK_NONE;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        o_emit        = 1'b0;
        o_token.start = 1'b0;
        o_token.kind  = body_kind;
        o_token.arg   = body_arg;
        case (r_phase)
            PH_HEADER: begin
                if (i_char == CH_HASH || i_char == CH_X) begin
                    n_phase = PH_SKIPLINE;
                end else if (i_char != CH_NL) begin
                    o_emit        = 1'b1;
                    o_token.start = 1'b1;
                    n_phase       = (body_kind == TK_END) ? PH_DONE : PH_BODY;
                end
            end
            PH_SKIPLINE: begin
                if (i_char == CH_NL) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_BODY: begin
                o_emit = (body_kind != TK_NONE);
                if (body_kind == TK_END) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

>>> rtl/lrle_fifo.sv
// Short token queue between front and back ends
`timescale 1ns / 1ps
module lrle_fifo
    import lrle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_token
);

    t_token             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               push_ok;
    logic               pop_ok;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/lrle_back.sv
// Back end: run count, cursor, clipping and the result register
`timescale 1ns / 1ps
module lrle_back
    import lrle_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tok_valid,
    input  t_token     i_token,
    output logic       o_pop,
    input  logic [9:0] i_origin_x,
    input  logic [8:0] i_origin_y,
    input  logic       i_out_ready,
    output logic       o_valid,
    output logic [9:0] o_run_x,
    output logic [8:0] o_run_y,
    output logic [9:0] o_run_length,
    output logic       o_alive,
    output logic       o_clipped,
    output logic       o_pattern_end
);

    localparam int XW  = $clog2(GRID_WIDTH + 1);
    localparam int YW  = $clog2(GRID_HEIGHT + 1);
    localparam int XSW = ((XW > 10) ? XW : 10) + 1;
    localparam int YSW = ((YW > 10) ? YW : 10) + 1;
    localparam logic [XSW-1:0] GW = XSW'(GRID_WIDTH);
    localparam logic [YSW-1:0] GH = YSW'(GRID_HEIGHT);

    logic [XW-1:0] r_cx, n_cx;
    logic [YW-1:0] r_cy, n_cy;
    logic [9:0]    r_count, n_count;
    logic          r_seen, n_seen;
    logic          r_valid, n_valid;
    logic [9:0]    r_run_x, n_run_x;
    logic [8:0]    r_run_y, n_run_y;
    logic [9:0]    r_len, n_len;
    logic          r_alive, n_alive;
    logic          r_clip, n_clip;
    logic          r_end, n_end;

    logic [XSW-1:0] ox_ext, ox_cl, cx_ext, nx_ext, avail, x_sum, len_ext;
    logic [YSW-1:0] oy_ext, oy_cl, cy_ext, ny_ext, y_sum;
    logic [9:0]     cnt_base, n_take;
    logic           seen_base, off_grid;
    logic [13:0]    prod;
    logic           has_out;

    always_comb begin
        ox_ext = XSW'(i_origin_x);
        ox_cl  = (ox_ext > GW) ? GW : ox_ext;
        oy_ext = YSW'(i_origin_y);
        oy_cl  = (oy_ext > GH) ? GH : oy_ext;

        cx_ext    = i_token.start ? ox_cl : XSW'(r_cx);
        cy_ext    = i_token.start ? oy_cl : YSW'(r_cy);
        cnt_base  = i_token.start ? 10'd0 : r_count;
        seen_base = i_token.start ? 1'b0 : r_seen;
        n_take    = seen_base ? cnt_base : 10'd1;

        off_grid = (cx_ext >= GW) || (cy_ext >= GH);
        avail    = GW - cx_ext;
        len_ext  = (XSW'(n_take) > avail) ? avail : XSW'(n_take);
        x_sum    = cx_ext + XSW'(n_take);
        nx_ext   = (x_sum > GW) ? GW : x_sum;
        y_sum    = cy_ext + YSW'(n_take);
        ny_ext   = (y_sum > GH) ? GH : y_sum;

        prod = (14'(cnt_base) << 3) + (14'(cnt_base) << 1) + 14'(i_token.arg);
    end

    assign has_out = (i_token.kind == TK_RUN) || (i_token.kind == TK_END);
    assign o_pop   = i_tok_valid && (!has_out || !r_valid || i_out_ready);

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_count  = r_count;
        n_seen   = r_seen;
        n_run_x  = r_run_x;
        n_run_y  = r_run_y;
        n_len    = r_len;
        n_alive  = r_alive;
        n_clip   = r_clip;
        n_end    = r_end;
        n_valid  = i_out_ready ? 1'b0 : r_valid;
        if (o_pop) begin
            n_cx    = cx_ext[XW-1:0];
            n_cy    = cy_ext[YW-1:0];
            n_count = cnt_base;
            n_seen  = seen_base;
            case (i_token.kind)
                TK_DIGIT: begin
                    n_count = (prod > 14'(COUNT_MAX)) ? COUNT_MAX : prod[9:0];
                    n_seen  = 1'b1;
                end
                TK_RUN: begin
                    n_valid = 1'b1;
                    n_run_x = cx_ext[9:0];
                    n_run_y = cy_ext[8:0];
                    n_len   = off_grid ? 10'd0 : len_ext[9:0];
                    n_clip  = off_grid || (XSW'(n_take) > avail);
                    n_alive = i_token.arg[0];
                    n_end   = 1'b0;
                    n_cx    = nx_ext[XW-1:0];
                    n_count = 10'd0;
                    n_seen  = 1'b0;
                end
                TK_ROW: begin
                    n_cy    = ny_ext[YW-1:0];
                    n_cx    = ox_cl[XW-1:0];
                    n_count = 10'd0;
                    n_seen  = 1'b0;
                end
                TK_END: begin
                    n_valid = 1'b1;
                    n_run_x = cx_ext[9:0];
                    n_run_y = cy_ext[8:0];
                    n_len   = 10'd0;
                    n_clip  = 1'b0;
                    n_alive = 1'b0;
                    n_end   = 1'b1;
                    n_count = 10'd0;
                    n_seen  = 1'b0;
                end
                default: begin
                    n_count = cnt_base;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_count <= '0;
            r_seen  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_x <= n_run_x;
        r_run_y <= n_run_y;
        r_len   <= n_len;
        r_alive <= n_alive;
        r_clip  <= n_clip;
        r_end   <= n_end;
    end

    assign o_valid       = r_valid;
    assign o_run_x       = r_run_x;
    assign o_run_y       = r_run_y;
    assign o_run_length  = r_len;
    assign o_alive       = r_alive;
    assign o_clipped     = r_clip;
    assign o_pattern_end = r_end;

endmodule

>>> rtl/life_rle_pattern_decoder.sv
// Top level: characters in, one word per cell run or end marker out.
// The word for a run or end marker passes through the token queue and the output register.
// One character is accepted per cycle while the token queue is not full.
// Words drain one per cycle when ready; a stalled output backs up through the four-entry queue.
// Reset (synchronous, active low): header phase, empty queue, count cleared, cursor and
// origins at zero, no word pending.
`timescale 1ns / 1ps
module life_rle_pattern_decoder
    import lrle_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // run_x, run_y, run_length, clipped, zero pad
    output logic        m_axis_tuser,   // alive
    output logic        m_axis_tlast,   // pattern_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic       sel_origin_x;
    logic [9:0] r_ox;
    logic [8:0] r_oy;
    logic       in_accept;
    logic       emit;
    t_token     front_tok;
    logic       fifo_full;
    logic       fifo_valid;
    t_token     fifo_tok;
    logic       pop;
    logic [9:0] run_x;
    logic [8:0] run_y;
    logic [9:0] run_length;
    logic       clipped;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !fifo_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign sel_origin_x  = (i_cfg_index == CFG_ORIGIN_X);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cfg_valid) begin
            if (sel_origin_x) begin
                r_ox <= i_cfg_data;
            end else if (i_cfg_index == CFG_ORIGIN_Y) begin
                r_oy <= i_cfg_data[8:0];
            end
        end
    end

    lrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_char  (s_axis_tdata),
        .o_emit  (emit),
        .o_token (front_tok)
    );

    lrle_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_accept && emit),
        .i_token(front_tok),
        .i_pop  (pop),
        .o_full (fifo_full),
        .o_valid(fifo_valid),
        .o_token(fifo_tok)
    );

    lrle_back #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (fifo_valid),
        .i_token      (fifo_tok),
        .o_pop        (pop),
        .i_origin_x   (r_ox),
        .i_origin_y   (r_oy),
        .i_out_ready  (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_run_x      (run_x),
        .o_run_y      (run_y),
        .o_run_length (run_length),
        .o_alive      (m_axis_tuser),
        .o_clipped    (clipped),
        .o_pattern_end(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, clipped, run_length, run_y, run_x};

endmodule

>>> rtl/lrle_checker.sv
// Port-level checks on the decoder's output stream, bound to the top level
`timescale 1ns / 1ps
`include "life_rle_pattern_decoder_assert.svh"
module lrle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic r_ended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
            r_ended <= 1'b1;
        end
    end

    `LRLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `LRLE_ASSERT_SAME(a_nothing_after_end, i_clk, i_rst_n, r_ended, !m_axis_tvalid)
    `LRLE_ASSERT_SAME(a_end_word_empty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[28:19] == 10'd0 && !m_axis_tuser && !m_axis_tdata[29])

endmodule

bind life_rle_pattern_decoder lrle_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

>>> tb/sv/tb_life_rle_pattern_decoder.sv
// Self-checking testbench of the Life RLE pattern decoder with a predicting scoreboard
`timescale 1ns / 1ps
module tb_life_rle_pattern_decoder;
    import lrle_pkg::*;

    localparam int CHAR_TARGET = 1450;
    localparam int QUIET_FROM  = 1300;
    localparam int PHASE_LEN   = 180;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 8;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_BODY,
        PH_DONE
    } t_parse_phase;

    typedef struct {
        logic [9:0] col;
        logic [8:0] row;
        logic [9:0] len;
        logic       alive;
        logic       clipped;
        logic       last;
    } t_run_word;

    class rle_scoreboard;
        t_parse_phase phase = PH_HEADER;
        int origin_x = 0;
        int origin_y = 0;
        int pending_count = 0;
        bit has_count = 1'b0;
        int col = 0;
        int row = 0;
        t_run_word runs_due[$];
        int errors = 0;
        int words_checked = 0;
        int live_words = 0;
        int clipped_words = 0;
        int end_markers = 0;
        int reg_writes = 0;

        function int clamp_to(int v, int lim);
            return (v > lim) ? lim : v;
        endfunction

        function int take_count();
            int n;
            n = has_count ? pending_count : 1;
            pending_count = 0;
            has_count = 1'b0;
            return n;
        endfunction

        function void write_reg(logic idx, logic [9:0] v);
            reg_writes++;
            if (idx == CFG_ORIGIN_X) origin_x = v;
            else origin_y = v[8:0];
        endfunction

        function void decode_body(logic [7:0] c);
            int n;
            t_run_word w;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                pending_count = clamp_to(pending_count * 10 + int'(c - CH_ZERO),
                                         int'(COUNT_MAX));
                has_count = 1'b1;
            end else if (c == CH_B || c == CH_O) begin
                n = take_count();
                w.col = col[9:0];
                w.row = row[8:0];
                w.len = '0;
                w.alive = (c == CH_O);
                w.clipped = 1'b0;
                w.last = 1'b0;
                if (col >= GRID_WIDTH_DEF || row >= GRID_HEIGHT_DEF) begin
                    w.clipped = 1'b1;
                end else if (n > GRID_WIDTH_DEF - col) begin
                    w.len = 10'(GRID_WIDTH_DEF - col);
                    w.clipped = 1'b1;
                end else begin
                    w.len = 10'(n);
                end
                runs_due.push_back(w);
                col = clamp_to(col + n, GRID_WIDTH_DEF);
            end else if (c == CH_DOLLAR) begin
                n = take_count();
                row = clamp_to(row + n, GRID_HEIGHT_DEF);
                col = clamp_to(origin_x, GRID_WIDTH_DEF);
            end else if (c == CH_BANG) begin
                pending_count = 0;
                has_count = 1'b0;
                w.col = col[9:0];
                w.row = row[8:0];
                w.len = '0;
                w.alive = 1'b0;
                w.clipped = 1'b0;
                w.last = 1'b1;
                runs_due.push_back(w);
                phase = PH_DONE;
            end
        endfunction

        function void note_char(logic [7:0] c);
            case (phase)
                PH_HEADER: begin
                    if (c == CH_HASH || c == CH_X) begin
                        phase = PH_SKIP;
                    end else if (c != CH_NL) begin
                        phase = PH_BODY;
                        pending_count = 0;
                        has_count = 1'b0;
                        col = clamp_to(origin_x, GRID_WIDTH_DEF);
                        row = clamp_to(origin_y, GRID_HEIGHT_DEF);
                        decode_body(c);
                    end
                end
                PH_SKIP: begin
                    if (c == CH_NL) phase = PH_HEADER;
                end
                PH_BODY: decode_body(c);
                default: ;
            endcase
        endfunction

        function int pending();
            return runs_due.size();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_run_word got);
            t_run_word want;
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual x=%0d y=%0d len=%0d",
                         $time, got.col, got.row, got.len);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            words_checked++;
            if (got.alive) live_words++;
            if (got.clipped) clipped_words++;
            if (got.last) end_markers++;
            compare_field("run_x", want.col, got.col);
            compare_field("run_y", want.row, got.row);
            compare_field("run_length", want.len, got.len);
            compare_field("alive", want.alive, got.alive);
            compare_field("clipped", want.clipped, got.clipped);
            compare_field("pattern_end", want.last, got.last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [9:0]  i_cfg_data = '0;

    rle_scoreboard sb = new();
    bit idle_on = 1'b1;
    int chars_sent = 0;
    int stall_left = 0;
    int cycle_count = 0;

    life_rle_pattern_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // hold tready low for a random burst now and then
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0) stall_left <= $urandom_range(1, 5);
        end
    end

    always @(posedge i_clk) begin
        t_run_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.col = m_axis_tdata[9:0];
            got.row = m_axis_tdata[18:10];
            got.len = m_axis_tdata[28:19];
            got.clipped = m_axis_tdata[29];
            got.alive = m_axis_tuser;
            got.last = m_axis_tlast;
            sb.check_word(got);
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_origin(input logic [9:0] x, input logic [8:0] y);
        logic [9:0] ydata;
        ydata = {1'($urandom_range(0, 1)), y};
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ORIGIN_X;
        i_cfg_data <= x;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_ORIGIN_X, x);
        i_cfg_index <= CFG_ORIGIN_Y;
        i_cfg_data <= ydata;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_ORIGIN_Y, ydata);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_BANG);
        send_char(c);
    endtask

    task automatic send_run_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= 30 && pick < 80) send_text($sformatf("%0d", $urandom_range(0, 30)));
        else if (pick >= 80 && pick < 95) send_text($sformatf("%0d", $urandom_range(100, 999)));
        else if (pick >= 95) send_text($sformatf("%0d", $urandom_range(1000, 99999)));
        send_char($urandom_range(0, 1) ? CH_O : CH_B);
    endtask

    initial begin
        logic [9:0] ox;
        int pick;
        int next_phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header: comment line with extreme bytes, blank line, size line
        set_origin(10'd1023, 9'd511);
        send_char(CH_HASH);
        send_char(8'hFF);
        send_char(8'h00);
        send_text("N\n\n");
        settle();
        set_origin(10'd0, 9'd0);
        send_text("x=3\n");
        settle();
        set_origin(10'($urandom_range(0, 200)), 9'($urandom_range(0, 200)));

        // body: digit opens the body, zero count, saturating count off the right edge,
        // run from an off-grid cursor, ignored characters keeping a count
        send_text("3o2b0o12345oo$1 2#b\r2$");

        next_phase = chars_sent + PHASE_LEN;
        while (chars_sent < CHAR_TARGET) begin
            if (chars_sent >= QUIET_FROM) begin
                idle_on = 1'b0;
            end else if (chars_sent >= next_phase) begin
                settle();
                case ($urandom_range(0, 4))
                    0: ox = 10'd0;
                    1: ox = 10'd1023;
                    2: ox = 10'($urandom_range(1000, 1022));
                    default: ox = 10'($urandom_range(0, 200));
                endcase
                set_origin(ox, 9'($urandom_range(0, 511)));
                idle_on = ($urandom_range(0, 3) != 0);
                next_phase = chars_sent + PHASE_LEN;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_run_token();
            end else if (pick < 65) begin
                if ($urandom_range(0, 9) < 3) send_text($sformatf("%0d", $urandom_range(1, 3)));
                send_char(CH_DOLLAR);
            end else if (pick < 75) begin
                send_char($urandom_range(0, 1) ? CH_NL : 8'h20);
            end else if (pick < 90) begin
                send_noise();
            end else begin
                send_text($sformatf("%0d", $urandom_range(1, 9)));
                send_noise();
                send_run_token();
            end
        end

        // drop off the bottom, then end with a count left pending and trailing text
        send_text("600$3ob7!o$b");
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Fed %0d characters with %0d origin writes; checked %0d words",
                 chars_sent, sb.reg_writes, sb.words_checked);
        $display("(%0d live runs, %0d clipped runs, %0d end markers)",
                 sb.live_words, sb.clipped_words, sb.end_markers);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
